// ===== hdl/atm_pkg.sv =====
// Package: shared constants, angle table and register index type for the tilt/magnitude unit.
`default_nettype none
package atm_pkg;
    localparam int CordicSteps = 22;
    localparam int AccW        = 25;
    localparam int SensW       = 10;
    localparam logic [SensW-1:0] SensReset = 10'd61;
    localparam logic [AccW-1:0] HalfTurn = 25'd4608000;
    localparam logic [AccW-1:0] FullTurn = 25'd9216000;
    localparam int RootBits    = 41;
    localparam int SqrtPerStg  = 3;
    localparam int SqrtStages  = 9;

    typedef enum logic [0:0] {
        REG_SENS = 1'b0
    } reg_idx_t;

    function automatic logic [AccW-1:0] atan_entry(input int i);
        logic [AccW-1:0] r;
        r = '0;
        case (i)
            0: r = 25'd1152000;
            1: r = 25'd680065;
            2: r = 25'd359328;
            3: r = 25'd182400;
            4: r = 25'd91554;
            5: r = 25'd45822;
            6: r = 25'd22916;
            7: r = 25'd11459;
            8: r = 25'd5730;
            9: r = 25'd2865;
            10: r = 25'd1432;
            11: r = 25'd716;
            12: r = 25'd358;
            13: r = 25'd179;
            14: r = 25'd90;
            15: r = 25'd45;
            16: r = 25'd22;
            17: r = 25'd11;
            18: r = 25'd6;
            19: r = 25'd3;
            20: r = 25'd1;
            21: r = 25'd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/atm_cordic.sv =====
// Pipelined CORDIC vectoring unit: direction of (a,b) in hundredths of a degree.
`default_nettype none
module atm_cordic #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                          clk,
    input  wire                          en,
    input  wire signed [SAMPLE_BITS-1:0] a,
    input  wire signed [SAMPLE_BITS-1:0] b,
    output logic [15:0]                  angle
);
    import atm_pkg::*;

    localparam int CW = SAMPLE_BITS + 20 + 3;

    logic signed [CW-1:0] x_reg [0:CordicSteps];
    logic signed [CW-1:0] y_reg [0:CordicSteps];
    logic [AccW-1:0]      acc_reg [0:CordicSteps];
    logic                 zero_reg [0:CordicSteps];
    logic [15:0]          angle_reg;
    logic [AccW-1:0]      fin;
    logic [AccW-1:0]      cd;

    // stage 0: prescale and fold into right half plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (a == '0) && (b == '0);
            if (a < 0)
            begin
                x_reg[0]   <= -($signed({{3{a[SAMPLE_BITS-1]}}, a, 20'd0}));
                y_reg[0]   <= -($signed({{3{b[SAMPLE_BITS-1]}}, b, 20'd0}));
                acc_reg[0] <= HalfTurn;
            end
            else
            begin
                x_reg[0]   <= $signed({{3{a[SAMPLE_BITS-1]}}, a, 20'd0});
                y_reg[0]   <= $signed({{3{b[SAMPLE_BITS-1]}}, b, 20'd0});
                acc_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] - atan_entry(i);
                end
            end
        end
    end

    always_comb
    begin
        fin = acc_reg[CordicSteps];
        if (fin[AccW-1])
            fin = fin + FullTurn;
        cd = (fin + AccW'(128)) >> 8;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[CordicSteps])
                angle_reg <= 16'd18000;
            else if (cd >= AccW'(36000))
                angle_reg <= 16'(cd - AccW'(36000));
            else
                angle_reg <= cd[15:0];
        end
    end

    assign angle = angle_reg;
endmodule
`default_nettype wire

// ===== hdl/accel_tilt_and_magnitude_unit.sv =====
// Top level: accelerometer magnitude and three CORDIC tilt angles, fully pipelined.
// Path from input request acceptance to output valid: prescale, 22 CORDIC steps and a
// rounding stage; the magnitude path is padded to match.
// Throughput: one request per cycle; a stall freezes the whole pipeline in place.
// Reset: rst_n asynchronous, active low; clears valid bits and restores sensitivity to 61.
`default_nettype none
module accel_tilt_and_magnitude_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // {accel_z, accel_y, accel_x} from the lowest bit up: x, y, z, zero fill
    input  wire  [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // magnitude_mg, angle_zx_cdeg, angle_yz_cdeg, angle_xz_cdeg from the lowest bit up
    output logic [63:0] m_axis_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import atm_pkg::*;

    localparam int Lat = CordicSteps + 2;
    localparam int SqW = 2*SAMPLE_BITS + 2;
    localparam int MW  = SqW + 2*SensW;
    localparam int RW  = (MW + 1) / 2;
    localparam int SW2 = 2*SAMPLE_BITS;

    logic [SensW-1:0] sens_reg;
    logic [Lat-1:0]   vld_reg;
    logic             en;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SENS) ? {{(32-SensW){1'b0}}, sens_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sens_reg <= SensReset;
        else if (psel && penable && pwrite && paddr[2] == REG_SENS)
            sens_reg <= pwdata[SensW-1:0];
    end

    assign en = !vld_reg[Lat-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[Lat-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Lat-2:0], s_axis_tvalid};
    end

    logic signed [SAMPLE_BITS-1:0] ax, ay, az;
    assign ax = s_axis_tdata[SAMPLE_BITS-1:0];
    assign ay = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign az = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

    logic [15:0] ang_zx, ang_yz, ang_xz;
    atm_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_zx (.clk, .en, .a(ax), .b(az), .angle(ang_zx));
    atm_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_yz (.clk, .en, .a(az), .b(ay), .angle(ang_yz));
    atm_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_xz (.clk, .en, .a(az), .b(ax), .angle(ang_xz));

    // magnitude: squares, sum, scale by k^2, restoring sqrt three root bits per stage
    logic [2*SAMPLE_BITS-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [SqW-1:0]           sum_reg;
    logic [2*SensW-1:0]       kk_reg;
    logic [MW-1:0]            m_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= $unsigned(SW2'(ax) * SW2'(ax));
            sqy_reg <= $unsigned(SW2'(ay) * SW2'(ay));
            sqz_reg <= $unsigned(SW2'(az) * SW2'(az));
            kk_reg  <= (2*SensW)'(sens_reg) * (2*SensW)'(sens_reg);
            sum_reg <= SqW'(sqx_reg) + SqW'(sqy_reg) + SqW'(sqz_reg);
            m_reg   <= MW'(sum_reg) * MW'(kk_reg);
        end
    end

    localparam int NS = (RW + SqrtPerStg - 1) / SqrtPerStg;
    logic [MW-1:0]   sm_reg   [0:NS-1];
    logic [RW+1:0]   srem_reg [0:NS-1];
    logic [RW-1:0]   sr_reg   [0:NS];
    always_comb
    begin
        sm_reg[0]   = m_reg;
        srem_reg[0] = '0;
        sr_reg[0]   = '0;
    end
    // remainder form: two radicand bits in, one root bit out per step
    for (genvar s = 0; s < NS; s++)
    begin : g_sqrt
        logic [MW-1:0]  m;
        logic [RW+1:0]  rem;
        logic [RW+1:0]  trial;
        logic [RW-1:0]  r;
        always_comb
        begin
            m     = sm_reg[s];
            rem   = srem_reg[s];
            r     = sr_reg[s];
            trial = '0;
            for (int j = 0; j < SqrtPerStg; j++)
            begin
                if (s*SqrtPerStg + j < RW)
                begin
                    rem   = {rem[RW-1:0], m[MW-1:MW-2]};
                    trial = {r, 2'b01};
                    if (rem >= trial)
                    begin
                        rem = rem - trial;
                        r   = {r[RW-2:0], 1'b1};
                    end
                    else
                        r = {r[RW-2:0], 1'b0};
                    m = m << 2;
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                sr_reg[s+1] <= r;
        end
        if (s < NS-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sm_reg[s+1]   <= m;
                    srem_reg[s+1] <= rem;
                end
            end
        end
    end

    // divide by 1000 as a reciprocal multiply; inputs past the saturation point are clipped
    localparam int ClipW    = 26;
    localparam int RecW     = 27;
    localparam int DivShift = 36;
    localparam int QW       = ClipW + RecW - DivShift;
    localparam logic [RecW-1:0] DivRecip = 27'd68719477;
    localparam logic [RW+26:0]  MagClip  = (RW+27)'(65536000);

    logic [RW-1:0]         rr_reg;
    logic [RW+26:0]        rr_ext;
    logic [ClipW-1:0]      rr_clip;
    logic [ClipW+RecW-1:0] prod;
    logic [QW-1:0]         q;
    logic [15:0] mag_reg;
    logic [15:0] mag_d_reg [0:Lat];
    always_ff @(posedge clk)
    begin
        if (en)
            rr_reg <= sr_reg[NS] + RW'(500);
    end
    assign rr_ext  = (RW+27)'(rr_reg);
    assign rr_clip = (rr_ext >= MagClip) ? MagClip[ClipW-1:0] : rr_ext[ClipW-1:0];
    assign prod    = (ClipW+RecW)'(rr_clip) * (ClipW+RecW)'(DivRecip);
    assign q       = prod[ClipW+RecW-1:DivShift];
    always_ff @(posedge clk)
    begin
        if (en)
            mag_reg <= q[QW-1] ? 16'hFFFF : q[15:0];
    end
    localparam int MagLat = 3 + NS + 2;
    localparam int Pad = Lat - MagLat;
    always_comb mag_d_reg[0] = mag_reg;
    for (genvar p = 0; p < Pad; p++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            if (en)
                mag_d_reg[p+1] <= mag_d_reg[p];
        end
    end

    assign m_axis_tdata = {ang_xz, ang_yz, ang_zx, mag_d_reg[Pad]};
endmodule
`default_nettype wire

// ===== hdl/atm_checker.sv =====
// Port-level checker for the tilt/magnitude unit, bound to the top level.
`default_nettype none
module atm_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [63:0] m_axis_tdata,
    input wire        pready
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_zx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:16] < 16'd36000)
        else $error("angle_zx out of range");
    a_xz_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:48] < 16'd36000)
        else $error("angle_xz out of range");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready && pready)
        else $error("input stalled with empty output");
endmodule

bind accel_tilt_and_magnitude_unit atm_checker u_atm_checker (
    .clk, .rst_n, .s_axis_tready, .m_axis_tvalid,
    .m_axis_tready, .m_axis_tdata, .pready
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the tilt and magnitude unit: random samples, self-checking predictor.
`timescale 1ns / 1ps
module tb_top;
    import atm_pkg::*;

    localparam int SampleW = 16;

    typedef struct packed {
        logic [15:0] mag;
        logic [15:0] ang_zx;
        logic [15:0] ang_yz;
        logic [15:0] ang_xz;
    } tilt_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [47:0] s_axis_tdata;   // accel_x, accel_y, accel_z from the lowest bit up
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [63:0] m_axis_tdata;   // magnitude, zx, yz, xz angles from the lowest bit up
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    accel_tilt_and_magnitude_unit #(.SAMPLE_BITS(SampleW)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [47:0] sample_queue[$];
    tilt_result_t expected_results[$];
    logic [9:0] sens_ug;
    int error_count;
    bit quiet_mode;
    int src_gap;
    int snk_gap;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] calc_magnitude(logic signed [15:0] x, logic signed [15:0] y,
                                                   logic signed [15:0] z, logic [9:0] k);
        logic [127:0] target;
        logic [127:0] cand;
        logic [63:0] r;
        logic [63:0] mg;
        logic [63:0] sum;
        longint xl;
        longint yl;
        longint zl;
        xl = x;
        yl = y;
        zl = z;
        sum = 64'(xl * xl + yl * yl + zl * zl);
        target = 128'(sum) * 128'(k) * 128'(k);
        r = 0;
        for (int b = 40; b >= 0; b--)
        begin
            cand = 128'(r | (64'd1 << b));
            if (cand * cand <= target)
                r = r | (64'd1 << b);
        end
        mg = (r + 500) / 1000;
        return (mg > 65535) ? 16'hFFFF : mg[15:0];
    endfunction

    function automatic logic [15:0] calc_direction(logic signed [15:0] a, logic signed [15:0] b);
        longint cx;
        longint cy;
        longint acc;
        longint dx;
        longint dy;
        longint c;
        if (a == 0 && b == 0)
            return 16'd18000;
        cx = longint'(a) * 1048576;
        cy = longint'(b) * 1048576;
        acc = 0;
        if (cx < 0)
        begin
            cx = -cx;
            cy = -cy;
            acc = longint'(HalfTurn);
        end
        for (int i = 0; i < CordicSteps; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0)
            begin
                cx += dx;
                cy -= dy;
                acc += longint'(atan_entry(i));
            end
            else
            begin
                cx -= dx;
                cy += dy;
                acc -= longint'(atan_entry(i));
            end
        end
        if (acc < 0)
            acc += longint'(FullTurn);
        c = (acc + 128) >>> 8;
        if (c >= 36000)
            c -= 36000;
        return c[15:0];
    endfunction

    // Driver: one request presented from the queue, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            src_gap <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (src_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (sample_queue.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= sample_queue.pop_front();
                if (!quiet_mode && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 13);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Predict on acceptance so expectations track the register value in use.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_results.push_back('{
                calc_magnitude(s_axis_tdata[15:0], s_axis_tdata[31:16],
                               s_axis_tdata[47:32], sens_ug),
                calc_direction(s_axis_tdata[15:0], s_axis_tdata[47:32]),
                calc_direction(s_axis_tdata[47:32], s_axis_tdata[31:16]),
                calc_direction(s_axis_tdata[47:32], s_axis_tdata[15:0])});
        end
    end

    // Monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        tilt_result_t exp_r;
        tilt_result_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            snk_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tdata[15:0], m_axis_tdata[31:16],
                        m_axis_tdata[47:32], m_axis_tdata[63:48]};
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r != got)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: exp mag %0d zx %0d yz %0d xz %0d, got %0d %0d %0d %0d",
                                     exp_r.mag, exp_r.ang_zx, exp_r.ang_yz, exp_r.ang_xz,
                                     got.mag, got.ang_zx, got.ang_yz, got.ang_xz);
                    end
                end
            end
            if (snk_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end
            else if (!quiet_mode && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                snk_gap <= $urandom_range(0, 12);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic write_sens(input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_SENS);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sens_ug = value[9:0];
    endtask

    task automatic drain_pipeline();
        while (sample_queue.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [47:0] pack_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 6) - 3);
            3: return 16'($urandom_range(0, 4000) - 2000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            sample_queue.push_back(pack_sample(rand_axis(), rand_axis(), rand_axis()));
    endtask

    initial
    begin
        logic [15:0] edge_vals[7];
        error_count = 0;
        quiet_mode = 0;
        sens_ug = SensReset;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0400, 16'hFC00};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: all-zero pairs, axis-aligned vectors, extremes, at reset sensitivity.
        sample_queue.push_back(pack_sample(0, 0, 0));
        foreach (edge_vals[i])
        begin
            sample_queue.push_back(pack_sample(edge_vals[i], 0, 0));
            sample_queue.push_back(pack_sample(0, edge_vals[i], 0));
            sample_queue.push_back(pack_sample(0, 0, edge_vals[i]));
        end
        sample_queue.push_back(pack_sample(16'h8000, 16'h8000, 16'h8000));
        sample_queue.push_back(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));
        sample_queue.push_back(pack_sample(16'h0001, 16'hFFFF, 16'h0001));
        drain_pipeline();

        // Full scale sensitivity with the largest samples; the magnitude stays below saturation.
        write_sens(32'd1000);
        sample_queue.push_back(pack_sample(16'h8000, 16'h8000, 16'h8000));
        sample_queue.push_back(pack_sample(16'h7FFF, 16'h0000, 16'h0000));
        queue_random(300);
        drain_pipeline();

        // Zero sensitivity and bits above the register width.
        write_sens(32'hFFFF_FC00);
        queue_random(200);
        drain_pipeline();

        write_sens(32'd1);
        queue_random(300);
        drain_pipeline();

        write_sens(32'h0000_03FF);
        queue_random(300);
        drain_pipeline();

        write_sens(32'd61);
        queue_random(500);
        drain_pipeline();

        // Final stretch with no idling on either side.
        write_sens(32'($urandom_range(1, 1000)));
        quiet_mode = 1;
        queue_random(350);
        drain_pipeline();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
